### hdl/disk_seek_distance_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the disk seek distance scheduler
// Shared assertion forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISK_SEEK_DISTANCE_SCHEDULER_MACROS_SVH
`define DISK_SEEK_DISTANCE_SCHEDULER_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define DSDS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define DSDS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/dsds_pkg.sv
// ----------------------------------------------------------------------------
// Disk seek distance scheduler package
// Policy, error, operation and register codes and the control group of the request cells.
// ----------------------------------------------------------------------------
package dsds_pkg;

	localparam logic [2:0] POL_FCFS  = 3'd0;
	localparam logic [2:0] POL_SSTF  = 3'd1;
	localparam logic [2:0] POL_SCAN  = 3'd2;
	localparam logic [2:0] POL_CSCAN = 3'd3;
	localparam logic [2:0] POL_LOOK  = 3'd4;
	localparam logic [2:0] POL_CLOOK = 3'd5;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_FULL  = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;

	localparam logic OP_HEAD = 1'b0;
	localparam logic OP_REQ  = 1'b1;

	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_COUNT  = 1'b1;

	localparam int COUNT_W = 17;

	typedef struct packed {
		logic shift;
		logic clr;
	} cell_ctrl_t;

endpackage

### hdl/disk_seek_distance_scheduler.sv
// ----------------------------------------------------------------------------
// Disk seek distance scheduler
// Loads a head position and a list of requests into a ring of cells and works
// out the total head movement under the selected policy.
// ----------------------------------------------------------------------------
// Each request loads into the ring, which takes one request per cycle while idle.
// A last request starts a check pass and then one pass per step, each pass
// rotating the whole ring of MAX_REQUESTS cells past one comparator.
// The number of step passes is n (SSTF, C-LOOK), n + 1 (SCAN, C-SCAN, LOOK)
// or 0 for FCFS, unused policy codes and error results; input waits until the
// result is in the output register, which waits for the last one to be taken.
// Reset clears the cell marks, the state, counters and flags; policy 0, 5000 cylinders.
module disk_seek_distance_scheduler #(
	parameter int MAX_REQUESTS  = 256,
	parameter int CYLINDER_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	// cylinder, previous_cylinder, zero fill
	input  logic [((2*CYLINDER_BITS+7)/8)*8-1:0]    s_axis_tdata,
	// op
	input  logic                                    s_axis_tuser,
	input  logic                                    s_axis_tlast,
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// total_movement, error, zero fill
	output logic [39:0]                             m_axis_tdata,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic                                    cfg_index,
	input  logic [dsds_pkg::COUNT_W-1:0]            cfg_data
);
	import dsds_pkg::*;
	`include "disk_seek_distance_scheduler_macros.svh"

	localparam int CB   = CYLINDER_BITS;
	localparam int CW   = (CB > COUNT_W) ? CB : COUNT_W;
	localparam int JW   = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int NW   = $clog2(MAX_REQUESTS + 1);
	localparam int SW   = $clog2(MAX_REQUESTS + 2);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_STEP  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]         st_q;
	logic [2:0]         policy_q;
	logic [COUNT_W-1:0] count_q;
	logic [CB-1:0]      head_q;
	logic [CB-1:0]      prev_q;
	logic [NW-1:0]      n_q;
	logic [1:0]         err_q;
	logic [JW-1:0]      j_q;
	logic [SW-1:0]      steps_q;
	logic [CW-1:0]      cur_q;
	logic               up_q;
	logic               bad_q;
	logic [31:0]        acc_q;
	logic               mark_q;
	logic [JW-1:0]      mark_pos_q;
	logic               fa_q, fn_q, ff_q;
	logic [CW-1:0]      da_q, dn_q, df_q;
	logic [JW-1:0]      pa_q, pn_q, pf_q;
	logic [CW-1:0]      ra_q, rn_q, rf_q;
	logic [31:0]        res_total_q;
	logic [1:0]         res_err_q;
	logic               m_valid_q;
	logic [31:0]        m_total_q;
	logic [1:0]         m_err_q;

	logic [MAX_REQUESTS-1:0] c_valid;
	logic [MAX_REQUESTS-1:0] c_served;
	logic [CB-1:0]           c_cyl [MAX_REQUESTS];
	cell_ctrl_t              ctrl;

	logic [CB-1:0] in_cyl, in_prev;
	logic          acc_in, load, full, pass_end, finish;
	logic          hit, sv0, live, ahead0;
	logic [CW-1:0] r0, d0, end_w;
	logic          fa_n, fn_n, ff_n;
	logic [CW-1:0] da_n, dn_n, df_n, ra_n, rn_n, rf_n;
	logic [JW-1:0] pa_n, pn_n, pf_n;
	logic          sel_f;
	logic [CW-1:0] sel_d, sel_r;
	logic [JW-1:0] sel_p;
	logic [CW:0]   add;
	logic [32:0]   sum;
	logic [31:0]   acc_add;
	logic [CW-1:0] fdist;
	logic [32:0]   fsum;
	logic [NW:0]   steps_full;

	assign in_cyl  = s_axis_tdata[CB-1:0];
	assign in_prev = s_axis_tdata[2*CB-1:CB];
	assign s_axis_tready = (st_q == ST_IDLE);
	assign acc_in  = s_axis_tvalid && s_axis_tready;
	assign full    = (n_q >= NW'(MAX_REQUESTS));
	assign load    = acc_in && (s_axis_tuser == OP_REQ) && !full;
	assign pass_end = (j_q == JW'(MAX_REQUESTS - 1));
	assign finish  = (st_q == ST_DONE) && (!m_valid_q || m_axis_tready);
	assign cfg_ready = 1'b1;
	assign end_w   = CW'(count_q - COUNT_W'(1));

	assign ctrl.shift = load || (st_q == ST_CHECK) || (st_q == ST_STEP);
	assign ctrl.clr   = (acc_in && (s_axis_tuser == OP_HEAD)) || finish;

	generate
		for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
			logic          nv, ns;
			logic [CB-1:0] nc;
			if (i == MAX_REQUESTS - 1) begin : g_tail
				assign nv = load ? 1'b1 : c_valid[0];
				assign ns = load ? 1'b0 : sv0;
				assign nc = load ? in_cyl : c_cyl[0];
			end else begin : g_body
				assign nv = c_valid[i+1];
				assign ns = c_served[i+1];
				assign nc = c_cyl[i+1];
			end
			dsds_cell #(.CYLINDER_BITS(CB)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.nb_valid  (nv),
				.nb_served (ns),
				.nb_cyl    (nc),
				.valid     (c_valid[i]),
				.served    (c_served[i]),
				.cyl       (c_cyl[i])
			);
		end
	endgenerate

	always_comb begin
		hit    = mark_q && (j_q == mark_pos_q) && (st_q == ST_STEP);
		sv0    = c_served[0] || hit;
		r0     = CW'(c_cyl[0]);
		live   = c_valid[0] && !sv0 && (st_q == ST_STEP);
		d0     = (cur_q > r0) ? (cur_q - r0) : (r0 - cur_q);
		ahead0 = up_q ? (r0 >= cur_q) : (r0 <= cur_q);
		fa_n = fa_q; da_n = da_q; pa_n = pa_q; ra_n = ra_q;
		fn_n = fn_q; dn_n = dn_q; pn_n = pn_q; rn_n = rn_q;
		ff_n = ff_q; df_n = df_q; pf_n = pf_q; rf_n = rf_q;
		if (live && ahead0 && (!fa_q || d0 < da_q)) begin
			fa_n = 1'b1; da_n = d0; pa_n = j_q; ra_n = r0;
		end
		if (live && (!fn_q || d0 < dn_q)) begin
			fn_n = 1'b1; dn_n = d0; pn_n = j_q; rn_n = r0;
		end
		if (live && (!ff_q || d0 > df_q)) begin
			ff_n = 1'b1; df_n = d0; pf_n = j_q; rf_n = r0;
		end
		priority if (policy_q == POL_SSTF) begin
			sel_f = fn_n; sel_d = dn_n; sel_p = pn_n; sel_r = rn_n;
		end else if (policy_q == POL_CLOOK && !fa_n) begin
			sel_f = ff_n; sel_d = df_n; sel_p = pf_n; sel_r = rf_n;
		end else begin
			sel_f = fa_n; sel_d = da_n; sel_p = pa_n; sel_r = ra_n;
		end
		if (sel_f) begin
			add = (CW+1)'(sel_d);
		end else if (policy_q == POL_SCAN) begin
			add = (CW+1)'(up_q ? end_w - cur_q : cur_q);
		end else if (policy_q == POL_CSCAN) begin
			add = (CW+1)'(up_q ? end_w - cur_q : cur_q) + (CW+1)'(end_w);
		end else begin
			add = '0;
		end
		sum     = {1'b0, acc_q} + 33'(add);
		acc_add = sum[32] ? '1 : sum[31:0];
		fdist   = (cur_q > r0) ? (cur_q - r0) : (r0 - cur_q);
		fsum    = {1'b0, acc_q} + 33'(fdist);
		steps_full = (policy_q == POL_SSTF || policy_q == POL_CLOOK)
			? (NW+1)'(n_q) : (NW+1)'(n_q) + (NW+1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FCFS;
			count_q  <= COUNT_W'(5000);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POLICY: policy_q <= cfg_data[2:0];
				REG_COUNT:  count_q  <= cfg_data;
				default:    policy_q <= policy_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			head_q    <= '0;
			prev_q    <= '0;
			n_q       <= '0;
			err_q     <= ERR_NONE;
			j_q       <= '0;
			steps_q   <= '0;
			mark_q    <= 1'b0;
			fa_q      <= 1'b0;
			fn_q      <= 1'b0;
			ff_q      <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (acc_in) begin
						if (s_axis_tuser == OP_HEAD) begin
							head_q <= in_cyl;
							prev_q <= in_prev;
							n_q    <= '0;
							err_q  <= ERR_NONE;
						end else if (full) begin
							err_q <= ERR_FULL;
						end else begin
							n_q <= n_q + NW'(1);
						end
						if (s_axis_tlast) begin
							st_q <= ST_PREP;
						end
					end
				end
				ST_PREP: begin
					cur_q <= CW'(head_q);
					bad_q <= (count_q == '0) || (CW'(head_q) >= CW'(count_q));
					acc_q <= '0;
					j_q   <= '0;
					st_q  <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!pass_end) begin
						j_q <= j_q + JW'(1);
						if (c_valid[0]) begin
							cur_q <= r0;
							acc_q <= fsum[32] ? '1 : fsum[31:0];
							if (r0 >= CW'(count_q)) begin
								bad_q <= 1'b1;
							end
						end
					end else begin
						j_q    <= '0;
						cur_q  <= CW'(head_q);
						up_q   <= prev_q < head_q;
						mark_q <= 1'b0;
						fa_q   <= 1'b0;
						fn_q   <= 1'b0;
						ff_q   <= 1'b0;
						steps_q <= SW'(steps_full);
						if (err_q != ERR_NONE) begin
							res_err_q   <= err_q;
							res_total_q <= '0;
							st_q        <= ST_DONE;
						end else if (bad_q || (c_valid[0] && r0 >= CW'(count_q))) begin
							res_err_q   <= ERR_RANGE;
							res_total_q <= '0;
							st_q        <= ST_DONE;
						end else if (policy_q == POL_FCFS) begin
							res_err_q   <= ERR_NONE;
							res_total_q <= c_valid[0] ? (fsum[32] ? '1 : fsum[31:0]) : acc_q;
							st_q        <= ST_DONE;
						end else if (policy_q > POL_CLOOK || steps_full == '0) begin
							res_err_q   <= ERR_NONE;
							res_total_q <= '0;
							st_q        <= ST_DONE;
						end else begin
							res_err_q <= ERR_NONE;
							acc_q     <= '0;
							st_q      <= ST_STEP;
						end
					end
				end
				ST_STEP: begin
					if (!pass_end) begin
						j_q  <= j_q + JW'(1);
						fa_q <= fa_n; da_q <= da_n; pa_q <= pa_n; ra_q <= ra_n;
						fn_q <= fn_n; dn_q <= dn_n; pn_q <= pn_n; rn_q <= rn_n;
						ff_q <= ff_n; df_q <= df_n; pf_q <= pf_n; rf_q <= rf_n;
					end else begin
						j_q     <= '0;
						fa_q    <= 1'b0;
						fn_q    <= 1'b0;
						ff_q    <= 1'b0;
						acc_q   <= acc_add;
						mark_q  <= sel_f;
						mark_pos_q <= sel_p;
						steps_q <= steps_q - SW'(1);
						if (sel_f) begin
							cur_q <= sel_r;
						end else if (policy_q == POL_SCAN) begin
							cur_q <= up_q ? end_w : '0;
							up_q  <= !up_q;
						end else if (policy_q == POL_CSCAN) begin
							cur_q <= up_q ? '0 : end_w;
						end else if (policy_q == POL_LOOK) begin
							up_q <= !up_q;
						end
						if (steps_q == SW'(1)) begin
							res_total_q <= acc_add;
							st_q        <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (finish) begin
						m_total_q <= res_total_q;
						m_err_q   <= res_err_q;
						n_q       <= '0;
						err_q     <= ERR_NONE;
						st_q      <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, m_err_q, m_total_q};

	`DSDS_ASSERT_ALWAYS(a_count_bound, n_q <= NW'(MAX_REQUESTS), "request count above capacity")
	`DSDS_ASSERT_IMPLY(a_step_left, st_q == ST_STEP, steps_q != '0, "step pass with no step left")
	`DSDS_ASSERT_IMPLY(a_err_zero, m_valid_q && m_err_q != ERR_NONE, m_total_q == '0, "error result with movement")
	`DSDS_ASSERT_IMPLY(a_err_code, m_valid_q, m_err_q != 2'd3, "undefined error code")

endmodule

### hdl/dsds_cell.sv
// ----------------------------------------------------------------------------
// Request cell
// Holds one request cylinder with its valid and served marks, takes its
// neighbor's contents whenever the ring shifts and otherwise clears its marks on clr.
// ----------------------------------------------------------------------------
module dsds_cell #(
	parameter int CYLINDER_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dsds_pkg::cell_ctrl_t     ctrl,
	input  logic                     nb_valid,
	input  logic                     nb_served,
	input  logic [CYLINDER_BITS-1:0] nb_cyl,
	output logic                     valid,
	output logic                     served,
	output logic [CYLINDER_BITS-1:0] cyl
);
	import dsds_pkg::*;

	logic                     valid_q;
	logic                     served_q;
	logic [CYLINDER_BITS-1:0] cyl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			served_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q  <= nb_valid;
			served_q <= nb_served;
		end else if (ctrl.clr) begin
			valid_q  <= 1'b0;
			served_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			cyl_q <= nb_cyl;
		end
	end

	assign valid  = valid_q;
	assign served = served_q;
	assign cyl    = cyl_q;

endmodule

### tb/disk_seek_distance_scheduler_check.sv
// ----------------------------------------------------------------------------
// Seek distance checker
// Watches the request, result and register channels, predicts the total head
// movement and error code of every job and compares each result in order.
// ----------------------------------------------------------------------------
module disk_seek_distance_scheduler_check
	import dsds_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         s_axis_tlast,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [39:0]  m_axis_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [16:0]  cfg_data,
	output int           fail_count,
	output int           pending,
	output int           job_count,
	output int           error_jobs
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] total;
		logic [1:0]  err;
	} seek_result_t;

	seek_result_t expected_moves[$];
	logic [2:0]   policy;
	logic [16:0]  cyl_count;
	logic [15:0]  req_cyl [256];
	bit           served [256];
	int           req_count;
	logic [15:0]  head_start;
	logic [15:0]  head_prev;
	logic [1:0]   err_latch;

	function automatic longint unsigned span(longint unsigned a, longint unsigned b);
		return a > b ? a - b : b - a;
	endfunction

	function automatic int nearest_ahead(longint unsigned pos, bit up,
			output longint unsigned d);
		int best;
		longint unsigned bd;
		best = -1;
		bd = 0;
		for (int i = 0; i < req_count; i++) begin
			if (served[i]) continue;
			if (up ? req_cyl[i] < pos : req_cyl[i] > pos) continue;
			if (best < 0 || span(pos, req_cyl[i]) < bd) begin
				best = i;
				bd = span(pos, req_cyl[i]);
			end
		end
		d = bd;
		return best;
	endfunction

	function automatic logic [31:0] head_travel();
		longint unsigned mv, cur, top, d, bd;
		bit up;
		int k, best;
		mv = 0;
		cur = head_start;
		top = cyl_count - 1;
		up = head_prev < head_start;
		for (int i = 0; i < 256; i++) served[i] = 0;
		case (policy)
			POL_FCFS: begin
				for (int i = 0; i < req_count; i++) begin
					mv += span(cur, req_cyl[i]);
					cur = req_cyl[i];
				end
			end
			POL_SSTF: begin
				for (int s = 0; s < req_count; s++) begin
					best = -1;
					bd = 0;
					for (int i = 0; i < req_count; i++) begin
						if (served[i]) continue;
						if (best < 0 || span(cur, req_cyl[i]) < bd) begin
							best = i;
							bd = span(cur, req_cyl[i]);
						end
					end
					mv += bd;
					cur = req_cyl[best];
					served[best] = 1;
				end
			end
			POL_SCAN, POL_CSCAN, POL_LOOK: begin
				for (int s = 0; s <= req_count; s++) begin
					k = nearest_ahead(cur, up, d);
					if (k >= 0) begin
						mv += d;
						cur = req_cyl[k];
						served[k] = 1;
					end else if (policy == POL_SCAN) begin
						mv += up ? top - cur : cur;
						cur = up ? top : 0;
						up = !up;
					end else if (policy == POL_CSCAN) begin
						mv += (up ? top - cur : cur) + top;
						cur = up ? 0 : top;
					end else begin
						up = !up;
					end
				end
			end
			POL_CLOOK: begin
				for (int s = 0; s < req_count; s++) begin
					k = nearest_ahead(cur, up, d);
					if (k < 0) begin
						bd = 0;
						for (int i = 0; i < req_count; i++) begin
							if (served[i]) continue;
							if (k < 0 || span(cur, req_cyl[i]) > bd) begin
								k = i;
								bd = span(cur, req_cyl[i]);
							end
						end
						d = bd;
					end
					mv += d;
					cur = req_cyl[k];
					served[k] = 1;
				end
			end
			default: mv = 0;
		endcase
		return mv > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : mv[31:0];
	endfunction

	function automatic void take_request(logic op, logic [15:0] cyl, logic [15:0] prev,
			logic lst);
		seek_result_t r;
		bit bad;
		if (op == OP_HEAD) begin
			head_start = cyl;
			head_prev = prev;
			req_count = 0;
			err_latch = ERR_NONE;
		end else if (req_count < 256) begin
			req_cyl[req_count] = cyl;
			req_count++;
		end else begin
			err_latch = ERR_FULL;
		end
		if (!lst) return;
		r.total = 0;
		r.err = err_latch;
		if (err_latch == ERR_NONE) begin
			bad = cyl_count == 0 || head_start >= cyl_count;
			for (int i = 0; i < req_count; i++)
				if (req_cyl[i] >= cyl_count) bad = 1;
			if (bad) r.err = ERR_RANGE;
			else r.total = head_travel();
		end
		expected_moves.push_back(r);
		req_count = 0;
		err_latch = ERR_NONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		seek_result_t want, got;
		if (!arst_n) begin
			expected_moves.delete();
			policy = POL_FCFS;
			cyl_count = 17'd5000;
			req_count = 0;
			head_start = 0;
			head_prev = 0;
			err_latch = ERR_NONE;
			fail_count = 0;
			pending = 0;
			job_count = 0;
			error_jobs = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.total = m_axis_tdata[31:0];
				got.err = m_axis_tdata[33:32];
				job_count++;
				if (got.err != ERR_NONE) error_jobs++;
				if (expected_moves.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: total %0d error %0d",
							got.total, got.err);
				end else begin
					want = expected_moves.pop_front();
					if (got.total !== want.total || got.err !== want.err) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result %0d: expected total %0d error %0d, got total %0d error %0d",
								job_count, want.total, want.err, got.total, got.err);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_POLICY) policy = cfg_data[2:0];
				else cyl_count = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready)
				take_request(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
					s_axis_tlast);
			pending = expected_moves.size();
		end
	end
endmodule

### tb/disk_seek_distance_scheduler_test.sv
// ----------------------------------------------------------------------------
// Seek distance scheduler test
// Drives head positions and request lists under every policy and a range of
// disk sizes, with random gaps and stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module disk_seek_distance_scheduler_test;
	import dsds_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = 0;
	logic        s_axis_tuser = 0;
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic        cfg_index = 0;
	logic [16:0] cfg_data = 0;

	int  fail_count, pending, job_count, error_jobs;
	int  sent = 0;
	int  quiet_cycles = 0;
	bit  quiet = 0;
	bit  hold_now = 0;

	always #6 clk = ~clk;

	disk_seek_distance_scheduler dut (.*);

	disk_seek_distance_scheduler_check checker_i (.*);

	initial begin
		forever begin
			@(negedge clk);
			if (hold_now) begin
				m_axis_tready = 0;
				repeat (3000) @(negedge clk);
				hold_now = 0;
			end else begin
				m_axis_tready = quiet || $urandom_range(0, 99) >= 9;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
		if (quiet_cycles >= 400000) begin
			$display("watchdog expired with %0d results outstanding", pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send(input logic op, input logic [15:0] cyl, input logic [15:0] prev,
			input logic lst);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 9) begin
			s_axis_tvalid = 0;
			@(negedge clk);
		end
		s_axis_tvalid = 1;
		s_axis_tuser = op;
		s_axis_tdata = {prev, cyl};
		s_axis_tlast = lst;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic write_reg(input logic idx, input logic [16:0] value);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 0;
		wait (pending == 0);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [15:0] pick_cyl(int unsigned cnt, int bad_pct);
		if (cnt == 0 || $urandom_range(0, 99) < bad_pct) return 16'($urandom());
		return 16'($urandom_range(0, cnt - 1));
	endfunction

	task automatic run_job(int unsigned cnt, int n, int bad_pct);
		logic [15:0] seen [$];
		logic [15:0] c;
		c = pick_cyl(cnt, bad_pct);
		seen.push_back(c);
		send(OP_HEAD, c, 16'($urandom()), n == 0);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 20) c = seen[$urandom_range(0, seen.size() - 1)];
			else c = pick_cyl(cnt, bad_pct);
			seen.push_back(c);
			send(OP_REQ, c, 16'($urandom()), i == n - 1);
		end
	endtask

	int unsigned counts [12] = '{65536, 16, 5000, 200, 1, 5000, 65536, 0, 4096, 3,
		65536, 1000};

	initial begin
		int base;
		repeat (5) @(negedge clk);
		arst_n = 1;

		// Policy FCFS on the reset disk of 5000 cylinders.
		send(OP_HEAD, 16'd0, 16'd0, 1'b1);
		send(OP_HEAD, 16'd4999, 16'hFFFF, 1'b0);
		send(OP_REQ, 16'd4999, 16'd0, 1'b0);
		send(OP_REQ, 16'd0, 16'd0, 1'b0);
		send(OP_REQ, 16'd0, 16'd0, 1'b0);
		send(OP_REQ, 16'd4999, 16'd0, 1'b1);
		send(OP_REQ, 16'd17, 16'd0, 1'b1);
		send(OP_HEAD, 16'd5000, 16'd0, 1'b1);
		send(OP_HEAD, 16'd100, 16'd200, 1'b0);
		send(OP_REQ, 16'hFFFF, 16'd0, 1'b1);
		send(OP_HEAD, 16'd2500, 16'd2400, 1'b0);
		send(OP_REQ, 16'd2499, 16'd0, 1'b0);
		send(OP_REQ, 16'd2501, 16'd0, 1'b0);
		send(OP_REQ, 16'd2500, 16'd0, 1'b1);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			if ($urandom_range(0, 1)) begin
				write_reg(REG_POLICY, 17'(ph % 8) | 17'($urandom_range(0, 4095) << 3));
				write_reg(REG_COUNT, 17'(counts[ph]));
			end else begin
				write_reg(REG_COUNT, 17'(counts[ph]));
				write_reg(REG_POLICY, 17'(ph % 8));
			end
			quiet = ph == 5;
			if (ph == 2) hold_now = 1;
			if (ph == 3) begin
				run_job(counts[ph], 257, 0);
			end
			base = sent;
			while (sent < base + 27) begin
				if ($urandom_range(0, 9) == 0)
					send(1'($urandom_range(0, 1)), pick_cyl(counts[ph], 10),
						16'($urandom()), 1'b1);
				else
					run_job(counts[ph], $urandom_range(0, 99) < 3 ?
						$urandom_range(9, 40) : $urandom_range(1, 8), 8);
			end
			drain();
		end
		quiet = 0;

		$display("Ran %0d jobs (%0d flagged as errors) from %0d requests over 12 disk",
			job_count, error_jobs, sent);
		$display("setups, covering all six policies, unused policy codes and a full store.");
		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
